// ===== rtl/irrm_pkg.sv =====
`default_nettype none
package irrm_pkg;

   // slot map geometry
   localparam int NUM_SLOTS_DEF = 1024;
   localparam int WORD_BITS     = 64;
   localparam int BIT_IDX_W     = 6;

   // field widths
   localparam int START_W = 10;
   localparam int END_W   = 11;
   localparam int COUNT_W = 11;

   // accept counter saturation point
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1024);

   typedef struct packed {
      logic [START_W-1:0] range_start;
      logic [END_W-1:0]   range_end;
      logic               last_request;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] accepted_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/irrm_ram.sv =====
`default_nettype none
module irrm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/interval_range_reservation_map_top.sv =====
`default_nettype none
// channel   ports                               payload
// request   req_valid / req_ready / req_data    range_start, range_end, last_request
// response  rsp_valid / rsp_ready / rsp_data    accepted, accepted_count
//
// the slot map lives in a ram of 64-bit words; a request makes two passes over its words:
// one pass reads and checks the words, a second pass reads, ors in the
// interval mask and writes back, one word per cycle through the ram's read port
// empty intervals skip both passes; a rejected request stops at the first occupied word
// reset, and every transaction flagged last, starts a clearing sweep over all
// ceil(NUM_SLOTS / 64) words during which no request is taken
// a finished response waits in the output register while the next request is taken
module interval_range_reservation_map_top #(
   parameter int NUM_SLOTS = irrm_pkg::NUM_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire irrm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output irrm_pkg::rsp_type      rsp_data
);

   import irrm_pkg::*;

   localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WPTR_W    = $clog2(NUM_WORDS + 1);
   localparam int SLOT_W    = $clog2(NUM_SLOTS + 1);
   localparam int POS_W     = (SLOT_W > END_W) ? SLOT_W : END_W;
   localparam logic [POS_W-1:0]   SLOT_LIMIT = POS_W'(NUM_SLOTS);
   localparam logic [WADDR_W-1:0] LAST_WORD  = WADDR_W'(NUM_WORDS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SET,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [WADDR_W-1:0]     sweep_ff, sweep_in;
   logic [WADDR_W-1:0]     lo_word_ff, lo_word_in;
   logic [WADDR_W-1:0]     hi_word_ff, hi_word_in;
   logic [BIT_IDX_W-1:0]   lo_bit_ff, lo_bit_in;
   logic [BIT_IDX_W-1:0]   hi_bit_ff, hi_bit_in;
   logic [WPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [WADDR_W-1:0]     eval_ptr_ff, eval_ptr_in;
   logic                   pend_ff, pend_in;
   logic                   busy_ff, busy_in;
   logic                   last_ff, last_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en;
   logic [WADDR_W-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [WADDR_W-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   logic [POS_W-1:0]       start_ext, end_ext, lo_clip, hi_clip, hi_minus;
   logic [POS_W-1:0]       lo_word_full, hi_word_full;
   logic [WORD_BITS-1:0]   word_mask;
   logic                   issue, hit, last_eval;
   logic [COUNT_W-1:0]     count_next;

   // bitmap storage
   irrm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS),
      .ADDR_W(WADDR_W)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // clip the incoming interval to the slot range
   always_comb begin
      start_ext    = POS_W'(req_data.range_start);
      end_ext      = POS_W'(req_data.range_end);
      lo_clip      = (start_ext > SLOT_LIMIT) ? SLOT_LIMIT : start_ext;
      hi_clip      = (end_ext > SLOT_LIMIT) ? SLOT_LIMIT : end_ext;
      hi_minus     = hi_clip - POS_W'(1);
      lo_word_full = lo_clip >> BIT_IDX_W;
      hi_word_full = hi_minus >> BIT_IDX_W;
   end

   // interval bits inside the word whose read data is on hand
   always_comb begin
      word_mask = '1;
      if (eval_ptr_ff == lo_word_ff) begin
         word_mask = word_mask & ({WORD_BITS{1'b1}} << lo_bit_ff);
      end
      if (eval_ptr_ff == hi_word_ff) begin
         word_mask = word_mask &
                     ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit_ff));
      end
   end

   assign issue     = (rd_ptr_ff <= WPTR_W'(hi_word_ff));
   assign hit       = pend_ff && ((ram_rd_data & word_mask) != '0);
   assign last_eval = pend_ff && (eval_ptr_ff == hi_word_ff);

   // saturating count including this transaction when it is accepted
   always_comb begin
      count_next = count_ff;
      if (!busy_ff && (count_ff < COUNT_MAX)) begin
         count_next = count_ff + COUNT_W'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      lo_word_in   = lo_word_ff;
      hi_word_in   = hi_word_ff;
      lo_bit_in    = lo_bit_ff;
      hi_bit_in    = hi_bit_ff;
      rd_ptr_in    = rd_ptr_ff;
      eval_ptr_in  = eval_ptr_ff;
      pend_in      = pend_ff;
      busy_in      = busy_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = eval_ptr_ff;
      ram_wr_data  = ram_rd_data | word_mask;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr_ff[WADDR_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + WADDR_W'(1);
            if (sweep_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               last_in    = req_data.last_request;
               busy_in    = 1'b0;
               pend_in    = 1'b0;
               lo_word_in = lo_word_full[WADDR_W-1:0];
               hi_word_in = hi_word_full[WADDR_W-1:0];
               lo_bit_in  = lo_clip[BIT_IDX_W-1:0];
               hi_bit_in  = hi_minus[BIT_IDX_W-1:0];
               rd_ptr_in  = WPTR_W'(lo_word_full[WADDR_W-1:0]);
               if (hi_clip <= lo_clip) begin
                  // empty interval, nothing to check or mark
                  state_in = S_DONE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // stream reads, test each word as it returns
            pend_in     = issue;
            eval_ptr_in = rd_ptr_ff[WADDR_W-1:0];
            if (issue) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_ff + WPTR_W'(1);
            end
            if (hit) begin
               busy_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else if (last_eval) begin
               pend_in   = 1'b0;
               rd_ptr_in = WPTR_W'(lo_word_ff);
               state_in  = S_SET;
            end
         end
         S_SET: begin
            // read word n+1 while writing back word n
            pend_in     = issue;
            eval_ptr_in = rd_ptr_ff[WADDR_W-1:0];
            if (issue) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_ff + WPTR_W'(1);
            end
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (last_eval) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.accepted        = !busy_ff;
               rsp_data_in.accepted_count  = count_next;
               if (last_ff) begin
                  count_in = '0;
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  count_in = count_next;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_word_ff  <= lo_word_in;
      hi_word_ff  <= hi_word_in;
      lo_bit_ff   <= lo_bit_in;
      hi_bit_ff   <= hi_bit_in;
      rd_ptr_ff   <= rd_ptr_in;
      eval_ptr_ff <= eval_ptr_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== tb/tb_interval_range_reservation_map_top.sv =====
`timescale 1ns / 1ps

// slot map predictor and response scoreboard
class reservation_scoreboard;
   bit                occupied [irrm_pkg::NUM_SLOTS_DEF];
   int unsigned       granted_total;
   irrm_pkg::rsp_type pending_outcomes [$];
   int unsigned       mismatches;

   function void clear_map();
      foreach (occupied[i]) occupied[i] = 1'b0;
      granted_total = 0;
   endfunction

   // predict the outcome of one accepted request transaction
   function void note_request(irrm_pkg::req_type req);
      int unsigned       lo;
      int unsigned       hi;
      bit                busy;
      irrm_pkg::rsp_type outcome;
      lo   = req.range_start;
      hi   = req.range_end;
      busy = 1'b0;
      // both ends clip to the slot count
      if (lo > irrm_pkg::NUM_SLOTS_DEF) lo = irrm_pkg::NUM_SLOTS_DEF;
      if (hi > irrm_pkg::NUM_SLOTS_DEF) hi = irrm_pkg::NUM_SLOTS_DEF;
      for (int unsigned s = lo; s < hi; s++) begin
         if (occupied[s]) busy = 1'b1;
      end
      // free interval: reserve it, counter saturates
      if (!busy) begin
         for (int unsigned s = lo; s < hi; s++) occupied[s] = 1'b1;
         if (granted_total < irrm_pkg::COUNT_MAX) granted_total++;
      end
      outcome.accepted       = !busy;
      outcome.accepted_count = granted_total[irrm_pkg::COUNT_W-1:0];
      pending_outcomes.push_back(outcome);
      // closing request wipes the set after its outcome is formed
      if (req.last_request) clear_map();
   endfunction

   // compare one response transaction with the oldest prediction
   function void check_response(irrm_pkg::rsp_type rsp);
      irrm_pkg::rsp_type want;
      if (pending_outcomes.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected response, expected none, got accepted %0b count %0d",
                  $time, rsp.accepted, rsp.accepted_count);
      end else begin
         want = pending_outcomes.pop_front();
         if (rsp.accepted !== want.accepted) begin
            mismatches++;
            $display("%0t: accepted mismatch, expected %0b, got %0b",
                     $time, want.accepted, rsp.accepted);
         end
         if (rsp.accepted_count !== want.accepted_count) begin
            mismatches++;
            $display("%0t: accepted_count mismatch, expected %0d, got %0d",
                     $time, want.accepted_count, rsp.accepted_count);
         end
      end
   endfunction
endclass

module tb_interval_range_reservation_map_top;
   import irrm_pkg::*;

   localparam int          CLOCK_PERIOD     = 10;
   localparam int          RESET_CYCLES     = 5;
   localparam int unsigned LIMIT_CYCLES     = 1000000;
   localparam int          SETTLE_CYCLES    = 64;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          RANDOM_ITEMS     = 1300;
   localparam int          HOLD_SET         = 3;
   localparam int          SATURATION_SET   = 12;
   localparam int          SATURATION_LEN   = 1060;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_SHUT} sink_mode_type;
   typedef enum {SHAPE_INTERVAL, SHAPE_EMPTY, SHAPE_RAW} req_shape_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   reservation_scoreboard ledger = new();
   int unsigned           cycle_count     = 0;
   int unsigned           burst_left      = 0;
   bit                    sender_idle     = 1'b1;
   bit                    long_hold_asked = 1'b0;

   interval_range_reservation_map_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("interval_range_reservation_map_top verification failed");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_response(rsp_data);
   end

   // response sink: changing ready patterns plus one long hold-off on request
   initial begin : response_sink
      sink_mode_type mode;
      int unsigned   run;
      forever begin
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         mode = sink_mode_type'($urandom_range(0, 3));
         run  = (mode == SINK_SHUT) ? $urandom_range(1, 25) : $urandom_range(5, 60);
         repeat (run) begin
            case (mode)
               SINK_OPEN:   rsp_ready <= 1'b1;
               SINK_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(input int unsigned first, input int unsigned stop,
                                        input bit closing);
      req_type req;
      req.range_start  = first[START_W-1:0];
      req.range_end    = stop[END_W-1:0];
      req.last_request = closing;
      return req;
   endfunction

   // mostly well-formed intervals, some empty, some raw noise
   function automatic req_type random_req(input bit closing);
      req_type       req;
      req_shape_type shape;
      int unsigned   pick;
      int unsigned   first;
      int unsigned   span;
      pick  = $urandom_range(0, 99);
      shape = (pick < 70) ? SHAPE_INTERVAL : (pick < 82) ? SHAPE_EMPTY : SHAPE_RAW;
      // a narrow window now and then makes collisions likely
      first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 1023);
      req.range_start = first[START_W-1:0];
      case (shape)
         SHAPE_INTERVAL: begin
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 32);
            req.range_end = END_W'(first + span);
         end
         SHAPE_EMPTY: req.range_end = END_W'($urandom_range(0, first));
         default:     req.range_end = END_W'($urandom_range(0, 2047));
      endcase
      // a stray closing flag breaks a set early
      req.last_request = closing | ($urandom_range(0, 49) == 0);
      return req;
   endfunction

   task automatic lower_valid();
      if (!sender_idle) begin
         req_valid   <= 1'b0;
         sender_idle  = 1'b1;
      end
   endtask

   // sender works in bursts with random gaps
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         lower_valid();
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 24);
      end
   endtask

   // drive one request transaction and wait for its handshake
   task automatic offer_request(input req_type req);
      req_valid   <= 1'b1;
      req_data    <= req;
      sender_idle  = 1'b0;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.note_request(req);
      pace_sender();
   endtask

   task automatic drain_responses();
      lower_valid();
      while (ledger.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned made;
      int unsigned set_index;
      int unsigned set_len;
      req_type     req;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: full map, edges, empty intervals, clipping, closing requests
      offer_request(make_req(0, 1024, 1'b0));
      offer_request(make_req(0, 1, 1'b0));
      offer_request(make_req(1023, 1024, 1'b0));
      offer_request(make_req(5, 5, 1'b0));
      offer_request(make_req(1023, 0, 1'b0));
      offer_request(make_req(0, 0, 1'b1));
      offer_request(make_req(1023, 2047, 1'b0));
      offer_request(make_req(1022, 1024, 1'b0));
      offer_request(make_req(0, 1022, 1'b0));
      offer_request(make_req(1022, 1023, 1'b0));
      offer_request(make_req(1023, 1023, 1'b0));
      offer_request(make_req(512, 1536, 1'b1));
      offer_request(make_req(100, 200, 1'b0));
      offer_request(make_req(200, 300, 1'b0));
      offer_request(make_req(199, 201, 1'b0));
      offer_request(make_req(150, 150, 1'b0));
      offer_request(make_req(300, 1024, 1'b0));
      offer_request(make_req(0, 100, 1'b0));
      offer_request(make_req(341, 682, 1'b0));
      offer_request(make_req(682, 1365, 1'b1));
      offer_request(make_req(341, 682, 1'b0));
      offer_request(make_req(682, 1024, 1'b1));
      drain_responses();

      // random sets of requests, each closed by a last request
      made      = 0;
      set_index = 0;
      while (made < RANDOM_ITEMS) begin
         // long sink hold-off while the sender keeps offering
         if (set_index == HOLD_SET) begin
            long_hold_asked = 1'b1;
            burst_left      = 80;
         end
         // one long set, mostly empty intervals, pushes the counter into saturation
         if (set_index == SATURATION_SET) begin
            for (int i = 0; i < SATURATION_LEN; i++) begin
               req = make_req($urandom_range(0, 1023), 0, i == SATURATION_LEN - 1);
               if ($urandom_range(0, 19) == 0)
                  req.range_end = END_W'(req.range_start + $urandom_range(1, 4));
               else
                  req.range_end = END_W'($urandom_range(0, req.range_start));
               offer_request(req);
            end
            made += SATURATION_LEN;
         end
         set_len = $urandom_range(1, 40);
         for (int i = 0; i < set_len; i++) begin
            offer_request(random_req(i == set_len - 1));
            made++;
         end
         if (set_index % 9 == 4) drain_responses();
         set_index++;
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_outcomes.size() == 0) begin
         $display("interval_range_reservation_map_top verification clean");
      end else begin
         $display("interval_range_reservation_map_top verification failed");
      end
      $finish;
   end

endmodule
